### rtl/core/sliding_window_maximum_core_assert.svh
// assertion macros used by the sliding window maximum datapath
`ifndef SLIDING_WINDOW_MAXIMUM_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SWM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swm: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swm: next-cycle check failed");

`endif

### rtl/core/swm_pkg.sv
// shared constants, types and command structs of the sliding window maximum
package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int ADDR_W      = $clog2(WINDOW_MAX);
    localparam int OCC_W       = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W       = OCC_W + 1;
    localparam int POS_MOD     = 2 * WINDOW_MAX;
    localparam int POS_W       = $clog2(POS_MOD);
    localparam int WS_W        = 7;
    localparam int WS_RESET    = 3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [OCC_W-1:0]              occ_t;
    typedef logic [SUM_W-1:0]              sum_t;
    typedef logic [POS_W-1:0]              pos_t;
    typedef logic [WS_W-1:0]               ws_t;

    // which ring slot the candidate store reads next
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_NEXT_HEAD,
        RD_BACK,
        RD_NEW_BACK
    } rd_sel_t;

    typedef struct packed {
        logic    accept;
        logic    retire;
        logic    front_capture;
        logic    pop;
        logic    push;
        logic    emit;
        logic    finish;
        rd_sel_t rd_sel;
    } swm_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic retire_hit;
        logic pop_hit;
        logic filled;
        logic out_free;
    } swm_status_t;

endpackage

### rtl/core/swm_in_if.sv
// sample channel: valid, ready and one input item
interface swm_in_if;
    logic             valid;
    logic             ready;
    swm_pkg::sample_t sample;
    logic             end_of_sequence;

    modport source (output valid, output sample, output end_of_sequence, input ready);
    modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

### rtl/core/swm_out_if.sv
// result channel: valid, ready and one result item
interface swm_out_if;
    logic             valid;
    logic             ready;
    swm_pkg::sample_t window_max;
    logic             final_result;

    modport source (output valid, output window_max, output final_result, input ready);
    modport sink   (input valid, input window_max, input final_result, output ready);
endinterface

### rtl/core/swm_cfg_if.sv
// configuration write channel for the window size register
interface swm_cfg_if;
    logic         valid;
    logic         ready;
    swm_pkg::ws_t window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

### rtl/core/swm_ctrl.sv
// sequencing state machine: accept, retire old entries, pop smaller entries, emit
module swm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  swm_pkg::swm_status_t status,
    output swm_pkg::swm_cmd_t    cmd,
    output logic                 in_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RETIRE,
        ST_POP,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = swm_pkg::RD_HEAD;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (status.in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_RETIRE;
                end
            end
            ST_RETIRE:
            begin
                if (status.retire_hit)
                begin
                    cmd.retire = 1'b1;
                    cmd.rd_sel = swm_pkg::RD_NEXT_HEAD;
                end
                else
                begin
                    cmd.front_capture = 1'b1;
                    cmd.rd_sel        = swm_pkg::RD_BACK;
                    state_next        = ST_POP;
                end
            end
            ST_POP:
            begin
                if (status.pop_hit)
                begin
                    cmd.pop    = 1'b1;
                    cmd.rd_sel = swm_pkg::RD_NEW_BACK;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!status.filled)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/swm_datapath.sv
// candidate ring store, deque pointers, window register and result register
`include "sliding_window_maximum_core_assert.svh"

module swm_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  swm_pkg::swm_cmd_t    cmd,
    output swm_pkg::swm_status_t status,
    input  logic                 in_valid,
    input  swm_pkg::sample_t     in_sample,
    input  logic                 in_eos,
    input  logic                 cfg_valid,
    input  swm_pkg::ws_t         cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output swm_pkg::sample_t     out_max,
    output logic                 out_final
);

    // candidate ring
    swm_pkg::sample_t mem_val [swm_pkg::WINDOW_MAX];
    swm_pkg::pos_t    mem_pos [swm_pkg::WINDOW_MAX];
    swm_pkg::sample_t rd_val_reg;
    swm_pkg::pos_t    rd_pos_reg;

    swm_pkg::ws_t     ws_reg;
    swm_pkg::addr_t   head_reg;
    swm_pkg::occ_t    occ_reg;
    swm_pkg::pos_t    pos_reg;
    logic             filled_reg;
    swm_pkg::sample_t sample_reg;
    logic             eos_reg;
    swm_pkg::occ_t    k_reg;
    swm_pkg::sample_t front_reg;
    swm_pkg::sample_t max_reg;
    logic             out_valid_reg;
    swm_pkg::sample_t out_max_reg;
    logic             out_final_reg;

    swm_pkg::occ_t    k_next;
    swm_pkg::occ_t    rd_off;
    swm_pkg::addr_t   rd_addr;
    swm_pkg::addr_t   wr_addr;
    swm_pkg::addr_t   head_inc;
    swm_pkg::pos_t    pos_inc;
    logic [swm_pkg::POS_W:0] age;
    logic             occ_zero;
    logic             fill_hit;

    function automatic swm_pkg::addr_t slot_of(swm_pkg::addr_t base, swm_pkg::occ_t off);
        swm_pkg::sum_t s;
        s = swm_pkg::sum_t'(base) + swm_pkg::sum_t'(off);
        if (s >= swm_pkg::sum_t'(swm_pkg::WINDOW_MAX))
        begin
            s = s - swm_pkg::sum_t'(swm_pkg::WINDOW_MAX);
        end
        return swm_pkg::addr_t'(s);
    endfunction

    assign occ_zero = (occ_reg == '0);

    // zero counts as one, oversize saturates
    always_comb
    begin
        if (ws_reg == '0)
        begin
            k_next = swm_pkg::occ_t'(1);
        end
        else if (swm_pkg::sum_t'(ws_reg) > swm_pkg::sum_t'(swm_pkg::WINDOW_MAX))
        begin
            k_next = swm_pkg::occ_t'(swm_pkg::WINDOW_MAX);
        end
        else
        begin
            k_next = swm_pkg::occ_t'(ws_reg);
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            swm_pkg::RD_HEAD:      rd_off = '0;
            swm_pkg::RD_NEXT_HEAD: rd_off = swm_pkg::occ_t'(1);
            swm_pkg::RD_BACK:
                rd_off = (occ_reg >= swm_pkg::occ_t'(1)) ? occ_reg - swm_pkg::occ_t'(1) : '0;
            swm_pkg::RD_NEW_BACK:
                rd_off = (occ_reg >= swm_pkg::occ_t'(2)) ? occ_reg - swm_pkg::occ_t'(2) : '0;
            default:               rd_off = '0;
        endcase
    end

    assign rd_addr  = slot_of(head_reg, rd_off);
    assign wr_addr  = slot_of(head_reg, occ_reg);
    assign head_inc = slot_of(head_reg, swm_pkg::occ_t'(1));
    assign pos_inc  = (pos_reg == swm_pkg::pos_t'(swm_pkg::POS_MOD - 1)) ? '0
                                                                         : pos_reg + 1'b1;

    // distance of the front entry from the current sample, modulo the position range
    always_comb
    begin
        if (pos_reg >= rd_pos_reg)
        begin
            age = {1'b0, pos_reg} - {1'b0, rd_pos_reg};
        end
        else
        begin
            age = {1'b0, pos_reg} + (swm_pkg::POS_W + 1)'(swm_pkg::POS_MOD)
                  - {1'b0, rd_pos_reg};
        end
    end

    assign fill_hit = (swm_pkg::sum_t'(pos_reg) + swm_pkg::sum_t'(1)) >= swm_pkg::sum_t'(k_reg);

    assign status.in_valid   = in_valid;
    assign status.retire_hit = !occ_zero
                               && (swm_pkg::sum_t'(age) >= swm_pkg::sum_t'(k_reg));
    assign status.pop_hit    = !occ_zero && (rd_val_reg < sample_reg);
    assign status.filled     = filled_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_max   = out_max_reg;
    assign out_final = out_final_reg;

    // ring store, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem_val[wr_addr] <= sample_reg;
            mem_pos[wr_addr] <= pos_reg;
        end
        rd_val_reg <= mem_val[rd_addr];
        rd_pos_reg <= mem_pos[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= in_sample;
            eos_reg    <= in_eos;
            k_reg      <= k_next;
        end
        if (cmd.front_capture)
        begin
            front_reg <= rd_val_reg;
        end
        if (cmd.push)
        begin
            max_reg <= occ_zero ? sample_reg : front_reg;
        end
        if (cmd.emit)
        begin
            out_max_reg   <= max_reg;
            out_final_reg <= eos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= swm_pkg::ws_t'(swm_pkg::WS_RESET);
            head_reg      <= '0;
            occ_reg       <= '0;
            pos_reg       <= '0;
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                ws_reg <= cfg_data;
            end
            if (cmd.retire)
            begin
                head_reg <= head_inc;
                occ_reg  <= occ_reg - 1'b1;
            end
            else if (cmd.pop)
            begin
                occ_reg <= occ_reg - 1'b1;
            end
            else if (cmd.push)
            begin
                if (occ_reg != swm_pkg::occ_t'(swm_pkg::WINDOW_MAX))
                begin
                    occ_reg <= occ_reg + 1'b1;
                end
                filled_reg <= filled_reg || fill_hit;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                if (eos_reg)
                begin
                    head_reg   <= '0;
                    occ_reg    <= '0;
                    pos_reg    <= '0;
                    filled_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_inc;
                end
            end
        end
    end

    `SWM_ASSERT_IMPLY(a_occ_bound, 1'b1, occ_reg <= swm_pkg::occ_t'(swm_pkg::WINDOW_MAX))
    `SWM_ASSERT_IMPLY(a_retire_nonempty, cmd.retire || cmd.pop, !occ_zero)
    `SWM_ASSERT_IMPLY(a_emit_filled, cmd.emit, filled_reg && (!out_valid_reg || out_ready))
    `SWM_ASSERT_NEXT(a_eos_clears, cmd.finish && eos_reg,
                     occ_reg == '0 && pos_reg == '0 && !filled_reg)

endmodule

### rtl/core/sliding_window_maximum_core.sv
// top level of the sliding window maximum: controller, datapath and channel wiring
// Emits, for every signed sample once the window has filled, the maximum of the
// last window_size samples (window_size 0 acts as 1, above 64 acts as 64). A
// monotonic deque of candidates lives in a 64-entry ring memory with one
// registered read port, and a controller walks it one entry a cycle. An item
// takes the controller through these steps in order: accept, retire entries off
// the front one at a time and then capture the front, pop smaller entries off
// the back one at a time and then write the new sample, and load the result
// register, a step that waits while the result register is still full. Every
// entry is retired or popped at most once. A sample with end_of_sequence set
// delivers its result, if the window has filled, and then clears the window; a
// sequence shorter than the window gives no result. The result register lets
// the next item be accepted and worked on while an earlier result waits to be
// taken. Configuration writes are taken in any cycle and should only be made
// while the block is idle.
module sliding_window_maximum_core (
    input  logic clk,
    input  logic rst_n,
    swm_in_if.sink    samples,
    swm_out_if.source results,
    swm_cfg_if.sink   cfg
);

    swm_pkg::swm_cmd_t    cmd;
    swm_pkg::swm_status_t status;
    logic                 in_ready;

    // the window register takes a write in every cycle
    assign cfg.ready     = 1'b1;
    assign samples.ready = in_ready;

    // sequencing: accept, front retire loop, back pop loop, result
    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    // candidate ring, deque pointers and result register
    swm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_valid  (samples.valid),
        .in_sample (samples.sample),
        .in_eos    (samples.end_of_sequence),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.window_size),
        .out_ready (results.ready),
        .out_valid (results.valid),
        .out_max   (results.window_max),
        .out_final (results.final_result)
    );

endmodule
